// File: rtl/brfo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package brfo_pkg;

   // Fixed field widths
   localparam int MODE_W = 3;
   localparam int DATA_W = 8;
   localparam int AMT_W  = 11;
   localparam int STAT_W = 2;
   localparam int LVL_W  = 11;
   localparam int CFG_W  = 4;

   // Reset value of the size register
   localparam logic [CFG_W-1:0] SIZE_LOG2_RESET = 4'd10;

   // Mode codes on the request channel
   localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FORCE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SKIP  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd5;

   // Status codes on the response channel
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_NONE  = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

   // Operation queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = 1;
   localparam int Q_CW    = 2;

   typedef enum logic [2:0] {
      OP_WRITE,
      OP_FORCE,
      OP_READ,
      OP_PEEK,
      OP_SKIP,
      OP_CLEAR,
      OP_BAD
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [DATA_W-1:0]   data;
      logic [AMT_W-1:0]    amount;
   } entry_type;

   function automatic op_type classify(input logic [MODE_W-1:0] mode);
      op_type op;
      case (mode)
         MODE_WRITE: op = OP_WRITE;
         MODE_FORCE: op = OP_FORCE;
         MODE_READ:  op = OP_READ;
         MODE_PEEK:  op = OP_PEEK;
         MODE_SKIP:  op = OP_SKIP;
         MODE_CLEAR: op = OP_CLEAR;
         default:    op = OP_BAD;
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

// File: rtl/brfo_front.sv
`timescale 1ns / 1ps
`default_nettype none

module brfo_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [brfo_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [brfo_pkg::DATA_W-1:0]   req_data_in,
   input  wire logic [brfo_pkg::AMT_W-1:0]    req_amount,
   output logic                               push_valid,
   input  wire logic                          push_ready,
   output brfo_pkg::entry_type                push_entry
);

   logic                valid_ff;
   logic                valid_in;
   brfo_pkg::entry_type entry_ff;
   logic                take;

   assign req_ready = !valid_ff || push_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Decode the mode once here so the back end sees a clean operation
   always_ff @(posedge clock) begin
      if (take) begin
         entry_ff.op     <= brfo_pkg::classify(req_mode);
         entry_ff.data   <= req_data_in;
         entry_ff.amount <= req_amount;
      end
   end

   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

endmodule

`default_nettype wire

// File: rtl/brfo_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module brfo_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output logic               push_ready,
   input  wire brfo_pkg::entry_type push_entry,
   output logic               pop_valid,
   input  wire logic          pop_ready,
   output brfo_pkg::entry_type pop_entry
);

   brfo_pkg::entry_type              slot_ff [brfo_pkg::Q_DEPTH];
   logic [brfo_pkg::Q_AW-1:0]        wr_ptr_ff;
   logic [brfo_pkg::Q_AW-1:0]        rd_ptr_ff;
   logic [brfo_pkg::Q_CW-1:0]        count_ff;
   logic                             do_push;
   logic                             do_pop;

   assign push_ready = (count_ff != brfo_pkg::Q_CW'(brfo_pkg::Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: rtl/brfo_back.sv
`timescale 1ns / 1ps
`default_nettype none

module brfo_back #(
   parameter int DEPTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_en,
   input  wire logic [brfo_pkg::CFG_W-1:0]    csr_write_data,
   input  wire logic                          pop_valid,
   output logic                               pop_ready,
   input  wire brfo_pkg::entry_type           pop_entry,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [brfo_pkg::DATA_W-1:0]        rsp_data_out,
   output logic [brfo_pkg::STAT_W-1:0]        rsp_status,
   output logic                               rsp_overwrote,
   output logic [brfo_pkg::LVL_W-1:0]         rsp_fill_level,
   output logic                               rsp_is_full,
   output logic                               rsp_is_empty
);

   // Largest power of two not above DEPTH sets pointer and store size
   localparam int MAXLG = $clog2(DEPTH + 1) - 1;
   localparam int PW    = MAXLG;
   localparam int CW    = (MAXLG + 1 > brfo_pkg::AMT_W) ? MAXLG + 1 : brfo_pkg::AMT_W;
   localparam int LW    = 5;

   logic [brfo_pkg::DATA_W-1:0]   store [2**PW];

   logic [PW-1:0]                 head_ff, head_in;
   logic [PW-1:0]                 tail_ff, tail_in;
   logic                          full_ff, full_in;
   logic [brfo_pkg::CFG_W-1:0]    size_ff;
   logic                          rsp_valid_ff;
   logic [brfo_pkg::DATA_W-1:0]   rdata_ff;
   logic                          dsel_ff, dsel_in;
   logic [brfo_pkg::STAT_W-1:0]   status_ff, status_in;
   logic                          over_ff, over_in;
   logic [brfo_pkg::LVL_W-1:0]    level_ff;
   logic                          is_full_ff;
   logic                          is_empty_ff;

   logic [LW-1:0]                 lg;
   logic [CW-1:0]                 cap;
   logic [PW-1:0]                 mask;
   logic [CW-1:0]                 used;
   logic [CW-1:0]                 used_nxt;
   logic [CW-1:0]                 amt;
   logic [CW-1:0]                 skip_n;
   logic [PW-1:0]                 head_adv;
   logic [PW-1:0]                 raddr;
   logic                          we;
   logic                          re;
   logic                          issue;

   assign issue     = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      lg   = ({1'b0, size_ff} < LW'(MAXLG)) ? {1'b0, size_ff} : LW'(MAXLG);
      cap  = CW'(1) << lg;
      mask = PW'(cap - CW'(1));
      used = full_ff ? cap : CW'((tail_ff - head_ff) & mask);
      amt  = CW'(pop_entry.amount);
      skip_n   = (amt < used) ? amt : used;
      head_adv = (head_ff + PW'(1)) & mask;
   end

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      full_in   = full_ff;
      status_in = brfo_pkg::ST_OK;
      over_in   = 1'b0;
      dsel_in   = 1'b0;
      we        = 1'b0;
      re        = 1'b0;
      raddr     = head_ff;
      case (pop_entry.op)
         brfo_pkg::OP_WRITE, brfo_pkg::OP_FORCE: begin
            if (full_ff && pop_entry.op == brfo_pkg::OP_WRITE) begin
               status_in = brfo_pkg::ST_NONE;
            end else begin
               if (full_ff) begin
                  head_in = head_adv;
                  over_in = 1'b1;
               end
               we      = 1'b1;
               tail_in = (tail_ff + PW'(1)) & mask;
               full_in = (tail_in == head_in);
            end
         end
         brfo_pkg::OP_READ: begin
            if (used == '0) begin
               status_in = brfo_pkg::ST_NONE;
            end else begin
               re      = 1'b1;
               dsel_in = 1'b1;
               head_in = head_adv;
               full_in = 1'b0;
            end
         end
         brfo_pkg::OP_PEEK: begin
            if (amt >= used) begin
               status_in = brfo_pkg::ST_RANGE;
            end else begin
               re      = 1'b1;
               dsel_in = 1'b1;
               raddr   = (head_ff + PW'(pop_entry.amount)) & mask;
            end
         end
         brfo_pkg::OP_SKIP: begin
            if (skip_n != '0) begin
               head_in = PW'(CW'(head_ff) + skip_n) & mask;
               full_in = 1'b0;
            end
         end
         brfo_pkg::OP_CLEAR: begin
            head_in = '0;
            tail_in = '0;
            full_in = 1'b0;
         end
         default: begin
            status_in = brfo_pkg::ST_NONE;
         end
      endcase
      used_nxt = full_in ? cap : CW'((tail_in - head_in) & mask);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         full_ff      <= 1'b0;
         size_ff      <= brfo_pkg::SIZE_LOG2_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            // New size: drop the pointers, keep the stored bytes
            size_ff <= csr_write_data;
            head_ff <= '0;
            tail_ff <= '0;
            full_ff <= 1'b0;
         end else if (issue) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
            full_ff <= full_in;
         end
         if (issue) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         dsel_ff     <= dsel_in;
         status_ff   <= status_in;
         over_ff     <= over_in;
         level_ff    <= used_nxt[brfo_pkg::LVL_W-1:0];
         is_full_ff  <= full_in;
         is_empty_ff <= (used_nxt == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (issue && we) begin
         store[tail_ff] <= pop_entry.data;
      end
      if (issue && re) begin
         rdata_ff <= store[raddr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_out   = dsel_ff ? rdata_ff : '0;
   assign rsp_status     = status_ff;
   assign rsp_overwrote  = over_ff;
   assign rsp_fill_level = level_ff;
   assign rsp_is_full    = is_full_ff;
   assign rsp_is_empty   = is_empty_ff;

endmodule

`default_nettype wire

// File: rtl/byte_ring_fifo_overwrite_peek.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                   Handshake
// request   req_mode, req_data_in, req_amount       req_valid / req_ready
// response  rsp_data_out, rsp_status, rsp_overwrote,
//           rsp_fill_level, rsp_is_full, rsp_is_empty  rsp_valid / rsp_ready
// config    csr_write_data (size_log2)              csr_write_en, no wait
//
// Sustained rate is one item per clock while rsp_ready stays high; the
// byte store's single port serves one operation per cycle. The accepted
// request passes the front register, two-entry queue and back register.
// Reset is synchronous and clears pointers, full flag and valids and sets
// size_log2 to 10; store contents are not cleared. Either side may stall:
// the queue decouples decode from the back end, which only issues when
// its output register is free.

module byte_ring_fifo_overwrite_peek #(
   parameter int DEPTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [brfo_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [brfo_pkg::DATA_W-1:0]   req_data_in,
   input  wire logic [brfo_pkg::AMT_W-1:0]    req_amount,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [brfo_pkg::DATA_W-1:0]        rsp_data_out,
   output logic [brfo_pkg::STAT_W-1:0]        rsp_status,
   output logic                               rsp_overwrote,
   output logic [brfo_pkg::LVL_W-1:0]         rsp_fill_level,
   output logic                               rsp_is_full,
   output logic                               rsp_is_empty,
   // size register
   input  wire logic                          csr_write_en,
   input  wire logic [brfo_pkg::CFG_W-1:0]    csr_write_data
);

   // Front to queue
   logic                push_valid;
   logic                push_ready;
   brfo_pkg::entry_type push_entry;

   // Queue to back
   logic                pop_valid;
   logic                pop_ready;
   brfo_pkg::entry_type pop_entry;

   // Accept and decode each item into an operation
   brfo_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_data_in (req_data_in),
      .req_amount  (req_amount),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_entry  (push_entry)
   );

   // Hold decoded operations while the back end is stalled
   brfo_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Execute against pointers and byte store, register the response
   brfo_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_entry      (pop_entry),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_out   (rsp_data_out),
      .rsp_status     (rsp_status),
      .rsp_overwrote  (rsp_overwrote),
      .rsp_fill_level (rsp_fill_level),
      .rsp_is_full    (rsp_is_full),
      .rsp_is_empty   (rsp_is_empty)
   );

endmodule

`default_nettype wire
